// ----- hw/rtl/svt_pkg.sv -----
// Shared constants, types and functions of the stereo triangulation pipeline.
`timescale 1ns / 1ps

package svt_pkg;

  // Rotation count of the sine/cosine cells.
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int NSTEP        = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

  // Datapath widths.
  localparam int XY_W  = 20;   // CORDIC vector components
  localparam int Z_W   = 28;   // CORDIC angle accumulator
  localparam int NUM_W = 41;   // dividend magnitude: B * |sin| * 2^15
  localparam int DEN_W = 16;   // divisor magnitude |sin(AO)|
  localparam int P_W   = 58;   // Q30 products and sums

  // Start vector 0.60725 in Q1.15.
  localparam logic signed [XY_W-1:0] CORDIC_K = XY_W'(19898);

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_PARALLEL = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  // One CORDIC lane: vector, residual angle and fold flag.
  typedef struct packed {
    logic [XY_W-1:0] x;
    logic [XY_W-1:0] y;
    logic [Z_W-1:0]  z;
    logic            neg;
  } cord_lane_t;

  // Word carried along the CORDIC chain.
  typedef struct packed {
    cord_lane_t  al;
    cord_lane_t  ar;
    cord_lane_t  ao;
    logic [10:0] b;
    logic        par;
  } cord_t;

  // Word carried along the divider chain.
  typedef struct packed {
    logic [NUM_W-1:0] nq;
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic [15:0]      sal;
    logic [15:0]      cal;
    logic [10:0]      b;
    logic             par;
  } div_t;

  // Arctangent of 2^-i in units of 1/4096 of 0.01 degree.
  function automatic logic [Z_W-1:0] atan_val(input logic [4:0] i);
    logic [Z_W-1:0] v;
    unique case (i)
      5'd0:  v = Z_W'(18432000);
      5'd1:  v = Z_W'(10881045);
      5'd2:  v = Z_W'(5749245);
      5'd3:  v = Z_W'(2918407);
      5'd4:  v = Z_W'(1464867);
      5'd5:  v = Z_W'(733147);
      5'd6:  v = Z_W'(366663);
      5'd7:  v = Z_W'(183343);
      5'd8:  v = Z_W'(91673);
      5'd9:  v = Z_W'(45837);
      5'd10: v = Z_W'(22918);
      5'd11: v = Z_W'(11459);
      5'd12: v = Z_W'(5730);
      5'd13: v = Z_W'(2865);
      5'd14: v = Z_W'(1432);
      5'd15: v = Z_W'(716);
      5'd16: v = Z_W'(358);
      5'd17: v = Z_W'(179);
      5'd18: v = Z_W'(90);
      5'd19: v = Z_W'(45);
      5'd20: v = Z_W'(22);
      5'd21: v = Z_W'(11);
      5'd22: v = Z_W'(6);
      5'd23: v = Z_W'(3);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Wrap an angle to [-180, 180), fold it into [-90, 90] and load a lane.
  function automatic cord_lane_t fold_angle(input logic signed [16:0] a);
    logic signed [16:0] r;
    cord_lane_t l;
    r = a;
    l.neg = 1'b0;
    if (r >= 17'sd18000) r = r - 17'sd36000;
    if (r < -17'sd18000) r = r + 17'sd36000;
    if (r > 17'sd9000) begin
      r = r - 17'sd18000;
      l.neg = 1'b1;
    end else if (r < -17'sd9000) begin
      r = r + 17'sd18000;
      l.neg = 1'b1;
    end
    l.x = CORDIC_K;
    l.y = '0;
    l.z = Z_W'(r) <<< 12;
    return l;
  endfunction

  // One rotation step with arithmetic shifts.
  function automatic cord_lane_t rotate(input cord_lane_t l, input logic [4:0] i);
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    cord_lane_t o;
    xs = $signed(l.x) >>> i;
    ys = $signed(l.y) >>> i;
    o.neg = l.neg;
    if (!l.z[Z_W-1]) begin
      o.x = $signed(l.x) - ys;
      o.y = $signed(l.y) + xs;
      o.z = $signed(l.z) - $signed(atan_val(i));
    end else begin
      o.x = $signed(l.x) + ys;
      o.y = $signed(l.y) - xs;
      o.z = $signed(l.z) + $signed(atan_val(i));
    end
    return o;
  endfunction

  // Undo the fold and clamp one component to Q1.15.
  function automatic logic [15:0] clamp_q15(input logic [XY_W-1:0] v, input logic neg);
    logic signed [XY_W:0] t;
    logic [15:0] r;
    t = neg ? -($signed({v[XY_W-1], v})) : $signed({v[XY_W-1], v});
    if (t > (XY_W+1)'(32767))       r = 16'h7fff;
    else if (t < -(XY_W+1)'(32768)) r = 16'h8000;
    else                            r = t[15:0];
    return r;
  endfunction

endpackage

// ----- hw/rtl/svt_if.sv -----
// Valid/ready channel interfaces for the input and result words.
`timescale 1ns / 1ps

interface svt_in_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] left_angle;
  logic signed [14:0] right_angle;
  logic        [10:0] baseline_mm;

  modport source (output valid, left_angle, right_angle, baseline_mm, input ready);
  modport sink   (input valid, left_angle, right_angle, baseline_mm, output ready);
endinterface

interface svt_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_mm;
  logic signed [15:0] depth_mm;
  logic        [1:0]  status;

  modport source (output valid, x_mm, depth_mm, status, input ready);
  modport sink   (input valid, x_mm, depth_mm, status, output ready);
endinterface

// ----- hw/rtl/svt_cordic_cell.sv -----
// One CORDIC rotation cell acting on the three angle lanes at once.
`timescale 1ns / 1ps

module svt_cordic_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [4:0]    step_i,
  input  logic          en_i,
  input  logic          valid_i,
  input  svt_pkg::cord_t data_i,
  output logic          valid_o,
  output svt_pkg::cord_t data_o
);

  logic           valid_q;
  svt_pkg::cord_t data_q, data_d;

  // Rotate all three lanes by the same step.
  always_comb begin
    data_d     = data_i;
    data_d.al  = svt_pkg::rotate(data_i.al, step_i);
    data_d.ar  = svt_pkg::rotate(data_i.ar, step_i);
    data_d.ao  = svt_pkg::rotate(data_i.ao, step_i);
  end

  // Valid flag follows the load enable.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- hw/rtl/svt_div_cell.sv -----
// One restoring-division cell: produces one quotient bit of RS.
`timescale 1ns / 1ps

module svt_div_cell (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  svt_pkg::div_t data_i,
  output logic         valid_o,
  output svt_pkg::div_t data_o
);

  logic          valid_q;
  svt_pkg::div_t data_q, data_d;
  logic [svt_pkg::DEN_W:0] trial;
  logic                    qbit;

  // Bring down the next dividend bit and try a subtraction.
  always_comb begin
    trial  = {data_i.rem, data_i.nq[svt_pkg::NUM_W-1]};
    qbit   = (trial >= {1'b0, data_i.den});
    data_d = data_i;
    if (qbit) begin
      data_d.rem = svt_pkg::DEN_W'(trial - {1'b0, data_i.den});
    end else begin
      data_d.rem = trial[svt_pkg::DEN_W-1:0];
    end
    data_d.nq = {data_i.nq[svt_pkg::NUM_W-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- hw/rtl/stereo_vergence_triangulation_top.sv -----
// Top level of the stereo triangulation pipeline.
//
//   channel  dir  fields                                   accepted when
//   in_i     in   left_angle, right_angle, baseline_mm     valid && ready
//   out_o    out  x_mm, depth_mm, status                   valid && ready
//
// One word enters per cycle while the output is not stalled; a word passes
// through the chain of rotation cells and the 41 divider cells, one bit per cell.
// Reset clears only the stage valid flags. A stalled output holds its word;
// stages behind it keep moving into empty slots, so input is taken while
// any bubble remains in the pipeline.
`timescale 1ns / 1ps

module stereo_vergence_triangulation_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  svt_in_if.sink    in_i,
  svt_out_if.source out_o
);

  localparam int N      = svt_pkg::NSTEP;
  localparam int NDIV   = svt_pkg::NUM_W;
  localparam int S_F1   = N + 1;
  localparam int S_F2   = N + 2;
  localparam int S_DIV0 = N + 3;
  localparam int S_M1   = S_DIV0 + NDIV;
  localparam int S_M2   = S_M1 + 1;
  localparam int S_M3   = S_M2 + 1;
  localparam int S_M4   = S_M3 + 1;
  localparam int L      = S_M4 + 1;
  localparam int P_W    = svt_pkg::P_W;

  logic [L-1:0] v;
  logic [L:0]   en;

  // A stage loads when it is empty or its word moves on.
  assign en[L] = out_o.ready;
  for (genvar k = 0; k < L; k++) begin : g_en
    assign en[k] = !v[k] | en[k+1];
  end
  assign in_i.ready = en[0];

  // Input stage: form the three angles and fold them.
  svt_pkg::cord_t     s0_q;
  logic               s0_v_q;
  logic signed [16:0] al, ar, ao;
  always_comb begin
    al = 17'sd9000 - 17'(in_i.left_angle);
    ar = 17'sd9000 + 17'(in_i.right_angle);
    ao = 17'(in_i.left_angle) - 17'(in_i.right_angle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en[0]) begin
      s0_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_q.al  <= svt_pkg::fold_angle(al);
      s0_q.ar  <= svt_pkg::fold_angle(ar);
      s0_q.ao  <= svt_pkg::fold_angle(ao);
      s0_q.b   <= in_i.baseline_mm;
      s0_q.par <= (ao == 17'sd0) || (ao == 17'sd18000) || (ao == -17'sd18000);
    end
  end
  assign v[0] = s0_v_q;

  // Chain of rotation cells.
  svt_pkg::cord_t cd [N+1];
  logic           cv [N+1];
  assign cd[0] = s0_q;
  assign cv[0] = s0_v_q;
  for (genvar i = 0; i < N; i++) begin : g_cordic
    svt_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (5'(i)),
      .en_i    (en[i+1]),
      .valid_i (cv[i]),
      .data_i  (cd[i]),
      .valid_o (cv[i+1]),
      .data_o  (cd[i+1])
    );
    assign v[i+1] = cv[i+1];
  end

  // Finish stage: undo folds and clamp sines and cosines.
  logic        f1_v_q;
  logic [15:0] f1_sal_q, f1_cal_q, f1_sar_q, f1_sao_q;
  logic [10:0] f1_b_q;
  logic        f1_par_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
    end else if (en[S_F1]) begin
      f1_v_q <= cv[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[S_F1]) begin
      f1_sal_q <= svt_pkg::clamp_q15(cd[N].al.y, cd[N].al.neg);
      f1_cal_q <= svt_pkg::clamp_q15(cd[N].al.x, cd[N].al.neg);
      f1_sar_q <= svt_pkg::clamp_q15(cd[N].ar.y, cd[N].ar.neg);
      f1_sao_q <= svt_pkg::clamp_q15(cd[N].ao.y, cd[N].ao.neg);
      f1_b_q   <= cd[N].b;
      f1_par_q <= cd[N].par;
    end
  end
  assign v[S_F1] = f1_v_q;

  // Divider setup: magnitudes and quotient sign.
  logic [15:0]         mag_ar, mag_ao;
  logic [26:0]         num_p;
  svt_pkg::div_t       f2_d;
  svt_pkg::div_t       f2_q;
  logic                f2_v_q;
  always_comb begin
    mag_ar     = f1_sar_q[15] ? 16'(-f1_sar_q) : f1_sar_q;
    mag_ao     = f1_sao_q[15] ? 16'(-f1_sao_q) : f1_sao_q;
    num_p      = 27'(f1_b_q) * 27'(mag_ar);
    f2_d.nq    = NDIV'({num_p, 15'd0});
    f2_d.rem   = '0;
    f2_d.den   = mag_ao;
    f2_d.neg   = f1_sar_q[15] ^ f1_sao_q[15];
    f2_d.sal   = f1_sal_q;
    f2_d.cal   = f1_cal_q;
    f2_d.b     = f1_b_q;
    f2_d.par   = f1_par_q || (f1_sao_q == 16'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_v_q <= 1'b0;
    end else if (en[S_F2]) begin
      f2_v_q <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[S_F2]) begin
      f2_q <= f2_d;
    end
  end
  assign v[S_F2] = f2_v_q;

  // Chain of divider cells.
  svt_pkg::div_t dd [NDIV+1];
  logic          dv [NDIV+1];
  assign dd[0] = f2_q;
  assign dv[0] = f2_v_q;
  for (genvar j = 0; j < NDIV; j++) begin : g_div
    svt_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[S_DIV0+j]),
      .valid_i (dv[j]),
      .data_i  (dd[j]),
      .valid_o (dv[j+1]),
      .data_o  (dd[j+1])
    );
    assign v[S_DIV0+j] = dv[j+1];
  end

  // Partial products of |RS| with sin(AL) and cos(AL).
  svt_pkg::div_t      dq;
  logic               m1_v_q;
  logic signed [33:0] m1_pdl_q, m1_pcl_q;
  logic signed [41:0] m1_pdh_q, m1_pch_q;
  logic               m1_neg_q, m1_par_q;
  logic [10:0]        m1_b_q;
  assign dq = dd[NDIV];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
    end else if (en[S_M1]) begin
      m1_v_q <= dv[NDIV];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[S_M1]) begin
      m1_pdl_q <= $signed({1'b0, dq.nq[15:0]}) * $signed(dq.sal);
      m1_pcl_q <= $signed({1'b0, dq.nq[15:0]}) * $signed(dq.cal);
      m1_pdh_q <= $signed({1'b0, dq.nq[NDIV-1:16]}) * $signed(dq.sal);
      m1_pch_q <= $signed({1'b0, dq.nq[NDIV-1:16]}) * $signed(dq.cal);
      m1_neg_q <= dq.neg;
      m1_par_q <= dq.par;
      m1_b_q   <= dq.b;
    end
  end
  assign v[S_M1] = m1_v_q;

  // Join partial products and apply the sign of RS.
  logic signed [P_W-1:0] sum_d, sum_c;
  logic signed [P_W-1:0] m2_pd_q, m2_pc_q;
  logic                  m2_v_q, m2_par_q;
  logic [10:0]           m2_b_q;
  always_comb begin
    sum_d = (P_W'(m1_pdh_q) <<< 16) + P_W'(m1_pdl_q);
    sum_c = (P_W'(m1_pch_q) <<< 16) + P_W'(m1_pcl_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_v_q <= 1'b0;
    end else if (en[S_M2]) begin
      m2_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[S_M2]) begin
      m2_pd_q  <= m1_neg_q ? -sum_d : sum_d;
      m2_pc_q  <= m1_neg_q ? -sum_c : sum_c;
      m2_par_q <= m1_par_q;
      m2_b_q   <= m1_b_q;
    end
  end
  assign v[S_M2] = m2_v_q;

  // Q30 depth and x with the rounding half added.
  localparam logic signed [P_W-1:0] HALF = P_W'(64'sd1 <<< 29);
  logic signed [P_W-1:0] m3_vd_q, m3_vx_q;
  logic                  m3_v_q, m3_par_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m3_v_q <= 1'b0;
    end else if (en[S_M3]) begin
      m3_v_q <= m2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[S_M3]) begin
      m3_vd_q  <= m2_pd_q + HALF;
      m3_vx_q  <= $signed({{(P_W-40){1'b0}}, m2_b_q, 29'd0}) - m2_pc_q + HALF;
      m3_par_q <= m2_par_q;
    end
  end
  assign v[S_M3] = m3_v_q;

  // Output register: shift out the fraction, saturate and set status.
  logic signed [P_W-31:0] rd, rx;
  logic                   sat_d, sat_x;
  logic [15:0]            od, ox;
  logic [1:0]             ost;
  always_comb begin
    rd    = (P_W-30)'(m3_vd_q >>> 30);
    rx    = (P_W-30)'(m3_vx_q >>> 30);
    sat_d = (rd > (P_W-30)'(32767)) || (rd < -(P_W-30)'(32768));
    sat_x = (rx > (P_W-30)'(32767)) || (rx < -(P_W-30)'(32768));
    od    = sat_d ? (rd[P_W-31] ? 16'h8000 : 16'h7fff) : rd[15:0];
    ox    = sat_x ? (rx[P_W-31] ? 16'h8000 : 16'h7fff) : rx[15:0];
    if (m3_par_q) begin
      od  = '0;
      ox  = '0;
      ost = svt_pkg::ST_PARALLEL;
    end else if (sat_d || sat_x) begin
      ost = svt_pkg::ST_SAT;
    end else begin
      ost = svt_pkg::ST_OK;
    end
  end

  logic        m4_v_q;
  logic [15:0] m4_x_q, m4_d_q;
  logic [1:0]  m4_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m4_v_q <= 1'b0;
    end else if (en[S_M4]) begin
      m4_v_q <= m3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[S_M4]) begin
      m4_x_q  <= ox;
      m4_d_q  <= od;
      m4_st_q <= ost;
    end
  end
  assign v[S_M4] = m4_v_q;

  assign out_o.valid    = m4_v_q;
  assign out_o.x_mm     = $signed(m4_x_q);
  assign out_o.depth_mm = $signed(m4_d_q);
  assign out_o.status   = m4_st_q;

endmodule

// ----- hw/rtl/svt_checker.sv -----
// Port-level checks of the triangulation block and their bind.
`timescale 1ns / 1ps

module svt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] x_mm_i,
  input logic [15:0] depth_mm_i,
  input logic [1:0]  status_i
);

  // A waiting result word stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // A waiting result word keeps its payload.
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(x_mm_i) && $stable(depth_mm_i) && $stable(status_i))
    else $error("result payload changed while stalled");

  // Parallel rays give zero position.
  a_par: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == svt_pkg::ST_PARALLEL |->
      x_mm_i == 16'd0 && depth_mm_i == 16'd0)
    else $error("parallel result with nonzero position");

  // A saturated result has at least one field at a limit.
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == svt_pkg::ST_SAT |->
      x_mm_i == 16'h7fff || x_mm_i == 16'h8000 ||
      depth_mm_i == 16'h7fff || depth_mm_i == 16'h8000)
    else $error("saturated status without a clamped field");

endmodule

bind stereo_vergence_triangulation_top svt_checker u_svt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .x_mm_i      (out_o.x_mm),
  .depth_mm_i  (out_o.depth_mm),
  .status_i    (out_o.status)
);

// ----- tb/svt_tb_checker.sv -----
// Checker for the stereo triangulation pipeline: predicts and compares result words.
`timescale 1ns / 1ps

module svt_tb_checker (
  input  logic clk_i,
  input  logic rst_ni,
  svt_in_if    in_c,
  svt_out_if   out_c,
  output int   err_count_o,
  output int   pending_o
);

  typedef struct {
    logic signed [15:0] x_mm;
    logic signed [15:0] depth_mm;
    logic [1:0]         status;
  } target_t;

  // Arctangent of 2^-i in 1/4096 of 0.01 degree.
  localparam int ATAN_UNITS [24] = '{
    18432000, 10881045, 5749245, 2918407, 1464867, 733147, 366663, 183343,
    91673, 45837, 22918, 11459, 5730, 2865, 1432, 716,
    358, 179, 90, 45, 22, 11, 6, 3
  };

  target_t target_q[$];
  int      err_count;
  int      print_count;

  assign err_count_o = err_count;
  assign pending_o   = target_q.size();

  // Sine and cosine of an angle in 0.01 degree, Q1.15, by vector rotation.
  function automatic void sin_cos_q15(input int ang, output int s, output int c);
    int r, x, y, z, nx;
    bit flip;
    r = ang % 36000;
    flip = 1'b0;
    if (r >= 18000) r -= 36000;
    if (r < -18000) r += 36000;
    if (r > 9000) begin
      r -= 18000;
      flip = 1'b1;
    end
    if (r < -9000) begin
      r += 18000;
      flip = 1'b1;
    end
    x = 19898;
    y = 0;
    z = r * 4096;
    for (int i = 0; i < svt_pkg::NSTEP; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_UNITS[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_UNITS[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = (y > 32767) ? 32767 : (y < -32768) ? -32768 : y;
    c = (x > 32767) ? 32767 : (x < -32768) ? -32768 : x;
  endfunction

  // Round a Q30 value to the nearest mm, half up, and clamp to 16 bits.
  function automatic logic signed [15:0] round_clamp(input longint v, inout bit sat);
    longint r;
    r = (v + (64'sd1 <<< 29)) >>> 30;
    if (r > 32767) begin
      sat = 1'b1;
      return 16'sh7fff;
    end
    if (r < -32768) begin
      sat = 1'b1;
      return -16'sh8000;
    end
    return r[15:0];
  endfunction

  // Triangulate one target from the two pan angles and the baseline.
  function automatic target_t triangulate(input logic signed [14:0] left,
                                          input logic signed [14:0] right,
                                          input logic [10:0] base);
    int al, ar, ao, s_al, c_al, s_ar, c_ar, s_ao, c_ao;
    longint b, ray, dq, xq;
    bit sat;
    target_t t;
    al = 9000 - int'(left);
    ar = 9000 + int'(right);
    ao = 18000 - (al + ar);
    b  = longint'(base);
    sat = 1'b0;
    sin_cos_q15(al, s_al, c_al);
    sin_cos_q15(ar, s_ar, c_ar);
    sin_cos_q15(ao, s_ao, c_ao);
    t.x_mm = '0;
    t.depth_mm = '0;
    t.status = svt_pkg::ST_OK;
    if (ao % 18000 == 0 || s_ao == 0) begin
      t.status = svt_pkg::ST_PARALLEL;
    end else begin
      ray = (b * longint'(s_ar) * 32768) / longint'(s_ao);
      dq  = ray * longint'(s_al);
      xq  = (b <<< 29) - ray * longint'(c_al);
      t.depth_mm = round_clamp(dq, sat);
      t.x_mm     = round_clamp(xq, sat);
      if (sat) t.status = svt_pkg::ST_SAT;
    end
    return t;
  endfunction

  task automatic report(input string what);
    err_count++;
    if (print_count < 30) begin
      print_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  // Queue a target for each accepted input word; compare each result word.
  always @(posedge clk_i or negedge rst_ni) begin
    target_t got, want;
    if (!rst_ni) begin
      target_q.delete();
    end else begin
      if (out_c.valid && out_c.ready) begin
        got.x_mm = out_c.x_mm;
        got.depth_mm = out_c.depth_mm;
        got.status = out_c.status;
        if (target_q.size() == 0) begin
          report("result word with no input pending");
        end else begin
          want = target_q.pop_front();
          if (got.x_mm !== want.x_mm)
            report($sformatf("x_mm got %0d want %0d", got.x_mm, want.x_mm));
          if (got.depth_mm !== want.depth_mm)
            report($sformatf("depth_mm got %0d want %0d", got.depth_mm, want.depth_mm));
          if (got.status !== want.status)
            report($sformatf("status got %0d want %0d", got.status, want.status));
        end
      end
      if (in_c.valid && in_c.ready)
        target_q.push_back(triangulate(in_c.left_angle, in_c.right_angle,
                                       in_c.baseline_mm));
    end
  end

  initial begin
    err_count = 0;
    print_count = 0;
  end

  // Anything still queued at the end counts once per word.
  task automatic flush_check();
    while (target_q.size() > 0) begin
      void'(target_q.pop_front());
      report("expected result word never arrived");
    end
  endtask

endmodule

// ----- tb/testbench.sv -----
// Top of the stereo triangulation testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 100;

  logic clk_i;
  logic rst_ni;
  int   err_count;
  int   pending;
  int   cycle_count;
  bit   quiet_phase;
  bit   hold_req;

  svt_in_if  in_ch ();
  svt_out_if out_ch ();

  stereo_vergence_triangulation_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  svt_tb_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_c        (in_ch),
    .out_c       (out_ch),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  // Clock with a 2 ns period.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Cycle counter that ends a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random stalls per word, plus one long hold-off on request.
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
      end
      n = quiet_phase ? 0 : $urandom_range(0, 7);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Offer one input word after a random gap and hold it until taken.
  task automatic send_word(input logic signed [14:0] left, input logic signed [14:0] right,
                           input logic [10:0] base, input bit no_gap);
    int n;
    n = (no_gap || quiet_phase) ? 0 : $urandom_range(0, 7);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    in_ch.left_angle  <= left;
    in_ch.right_angle <= right;
    in_ch.baseline_mm <= base;
    in_ch.valid       <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // Random word: mostly in range, some near-parallel, some raw bit patterns.
  task automatic send_random(input bit no_gap);
    int kind, l, r;
    logic [10:0] b;
    kind = $urandom_range(0, 99);
    b = $urandom_range(0, 2047);
    l = $urandom_range(0, 18000) - 9000;
    r = $urandom_range(0, 18000) - 9000;
    if (kind < 12) begin
      r = l + $urandom_range(0, 40) - 20;
      if (r > 9000) r = 9000;
    end else if (kind < 24) begin
      l = $urandom_range(0, 32767) - 16384;
      r = $urandom_range(0, 32767) - 16384;
    end else if (kind < 28) begin
      r = l - 18000;
      if (r < -16384) r = l + 18000 - 36000;
    end
    send_word(15'(l), 15'(r), b, no_gap);
  endtask

  // Stimulus and verdict.
  initial begin
    int wait_cycles;
    quiet_phase = 1'b0;
    hold_req = 1'b0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.left_angle = '0;
    in_ch.right_angle = '0;
    in_ch.baseline_mm = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed words: field extremes, parallel rays, saturation, wrapping.
    send_word(15'sd0, 15'sd0, 11'd100, 1'b0);
    send_word(15'sd1000, -15'sd1000, 11'd200, 1'b0);
    send_word(15'sd9000, -15'sd9000, 11'd2047, 1'b0);
    send_word(-15'sd9000, 15'sd9000, 11'd2047, 1'b0);
    send_word(15'sd9000, 15'sd9000, 11'd500, 1'b0);
    send_word(-15'sd9000, -15'sd9000, 11'd500, 1'b0);
    send_word(15'sd1, 15'sd0, 11'd2047, 1'b0);
    send_word(15'sd0, 15'sd1, 11'd2047, 1'b0);
    send_word(15'sd5, -15'sd5, 11'd2047, 1'b0);
    send_word(15'sd300, 15'sd250, 11'd0, 1'b0);
    send_word(15'sd16383, -15'sd16384, 11'd2047, 1'b0);
    send_word(-15'sd16384, 15'sd16383, 11'd1, 1'b0);
    send_word(15'sd16383, 15'sd16383, 11'd1024, 1'b0);
    send_word(-15'sd16384, -15'sd16384, 11'd1024, 1'b0);
    send_word(15'sd12000, -15'sd6000, 11'd1500, 1'b0);
    send_word(-15'sd12000, 15'sd6000, 11'd1500, 1'b0);
    send_word(15'sd100, -15'sd17900, 11'd800, 1'b0);
    send_word(15'sd4500, -15'sd4500, 11'd1, 1'b0);
    send_word(-15'sd2000, -15'sd3000, 11'd2046, 1'b0);
    send_word(15'sd8999, 15'sd8998, 11'd2047, 1'b0);

    for (int i = 0; i < 810; i++) begin
      quiet_phase = ((i / 100) % 4 == 2);
      if (i == 300) begin
        // Hold the result side while offering back to back to fill the pipe.
        hold_req = 1'b1;
        for (int k = 0; k < 120; k++) send_random(1'b1);
      end
      if (i == 600) begin
        // Pause until every pending result has come back.
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
      send_random(1'b0);
    end
    in_ch.valid <= 1'b0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 20000) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    repeat (DRAIN_WAIT) @(negedge clk_i);
    chk.flush_check();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
